// File: hdl/pbd_pkg.sv
// Shared types and constants for the pulse beat detector.
`timescale 1ns / 1ps
package pbd_pkg;

  localparam int HISTORY_DEPTH_DEF = 10;

  localparam int SAMPLE_W   = 10;
  localparam int ELAPSED_W  = 15;
  localparam int PERIOD_W   = 5;
  localparam int REFR_W     = 12;
  localparam int TIMEOUT_W  = 14;
  localparam int BPM_W      = 16;
  localparam int IVL_OUT_W  = 14;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL    = 4'd3;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET    = 5'd2;
  localparam logic [REFR_W-1:0]    REFR_RESET      = 12'd250;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 14'd2500;
  localparam logic [SAMPLE_W-1:0]  REST_RESET      = 10'd512;
  localparam logic [SAMPLE_W-1:0]  THRESH_RESET    = 10'd525;
  localparam int                   LAST_IVL_RESET  = 600;
  localparam int                   GATE_DIVISOR    = 5;
  localparam int                   GATE_MULT       = 3;
  localparam int                   GATE_RESET      = (LAST_IVL_RESET / GATE_DIVISOR) * GATE_MULT;
  localparam int                   GATE_SHIFT      = ELAPSED_W + $clog2(GATE_DIVISOR);
  localparam int                   GATE_RECIP      =
    ((1 << GATE_SHIFT) + GATE_DIVISOR - 1) / GATE_DIVISOR;
  localparam int                   BPM_NUMERATOR   = 60000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 15'h7FFF;
  localparam logic [IVL_OUT_W-1:0] IVL_OUT_MAX     = 14'h3FFF;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX      = 10'h3FF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_BPM_GO,
    S_BPM_WAIT,
    S_GATE,
    S_EMIT
  } state_t;

endpackage

// File: hdl/pulse_beat_detector.sv
// Top level: adaptive-threshold pulse beat detector with bpm averaging.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_sample           | sink
//  out     | out_valid, out_ready, out_pulse_active, | source
//          | out_beat_event, out_bpm, out_interval_ms,|
//          | out_threshold_level                     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink
//
// A sample without a beat passes through accept, evaluate and loading
// of the output register. The first beat after a start adds the gate
// step; a later beat also runs the divider for bpm before the gate
// step. Mean and gate come from reciprocal multiplication.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and a stalled out_ready holds the sequencer in its last step.
// rst_n is synchronous; the interval history holds no reset and is filled on the
// second beat after start or timeout.
`timescale 1ns / 1ps
module pulse_beat_detector
  import pbd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pulse_active,
  output logic                  out_beat_event,
  output logic [BPM_W-1:0]      out_bpm,
  output logic [IVL_OUT_W-1:0]  out_interval_ms,
  output logic [SAMPLE_W-1:0]   out_threshold_level,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W      = ELAPSED_W + $clog2(HISTORY_DEPTH);
  localparam int MEAN_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int MEAN_PW    = 2 * SUM_W + 2;
  localparam int GATE_PW    = 2 * ELAPSED_W + 2;
  localparam int DW         = BPM_W;
  localparam int VW         = ELAPSED_W;

  state_t state_r, state_nxt;

  logic [PERIOD_W-1:0]  period_r;
  logic [REFR_W-1:0]    refr_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [SAMPLE_W-1:0]  rest_r;

  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0] last_ivl_r, last_ivl_nxt;
  logic [ELAPSED_W-1:0] gate_r, gate_nxt;
  logic [SAMPLE_W-1:0]  peak_r, peak_nxt;
  logic [SAMPLE_W-1:0]  trough_r, trough_nxt;
  logic [SAMPLE_W-1:0]  thr_r, thr_nxt;
  logic                 in_pulse_r, in_pulse_nxt;
  logic                 first_r, first_nxt;
  logic                 second_r, second_nxt;
  logic [BPM_W-1:0]     bpm_r, bpm_nxt;
  logic                 event_r, event_nxt;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [ELAPSED_W-1:0] hist_r [HISTORY_DEPTH];
  logic                 hist_push;

  logic                 out_valid_r, out_valid_nxt;
  logic                 o_pulse_r;
  logic                 o_event_r;
  logic [BPM_W-1:0]     o_bpm_r;
  logic [IVL_OUT_W-1:0] o_ivl_r;
  logic [SAMPLE_W-1:0]  o_thr_r;
  logic                 out_load;

  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [VW-1:0]        div_divisor;
  logic                 div_busy;
  logic                 div_done;
  logic [DW-1:0]        div_quo;

  logic [ELAPSED_W:0]   elapsed_sum;
  logic [SAMPLE_W-1:0]  peak1, trough1, amp;
  logic [SAMPLE_W:0]    thr_sum;
  logic                 beat;
  logic [MEAN_PW-1:0]   mean_prod, mean_shr;
  logic [VW-1:0]        mean;
  logic [GATE_PW-1:0]   gate_prod, gate_shr;
  logic [ELAPSED_W-1:0] gate_q;
  logic [ELAPSED_W:0]   gate_calc;

  logic in_acc;
  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  pbd_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RESET;
      refr_r    <= REFR_RESET;
      timeout_r <= TIMEOUT_RESET;
      rest_r    <= REST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: period_r  <= cfg_data[PERIOD_W-1:0];
        CFG_REFRACTORY:    refr_r    <= cfg_data[REFR_W-1:0];
        CFG_TIMEOUT:       timeout_r <= cfg_data[TIMEOUT_W-1:0];
        CFG_REST_LEVEL:    rest_r    <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    elapsed_sum = {1'b0, elapsed_r} + {{(ELAPSED_W + 1 - PERIOD_W){1'b0}}, period_r};

    trough1 = trough_r;
    if (sample_r < thr_r && elapsed_r > gate_r && sample_r < trough_r) begin
      trough1 = sample_r;
    end
    peak1 = peak_r;
    if (sample_r > thr_r && sample_r > peak_r) begin
      peak1 = sample_r;
    end
    beat = (elapsed_r > {{(ELAPSED_W - REFR_W){1'b0}}, refr_r}) && (sample_r > thr_r) &&
           !in_pulse_r && (elapsed_r > gate_r);
    amp     = (peak1 > trough1) ? (peak1 - trough1) : '0;
    thr_sum = {2'b00, amp[SAMPLE_W-1:1]} + {1'b0, trough1};

    // mean = sum / HISTORY_DEPTH, gate = (last interval / 5) * 3
    mean_prod = MEAN_PW'(sum_r) * MEAN_PW'(MEAN_RECIP);
    mean_shr  = mean_prod >> MEAN_SHIFT;
    mean      = mean_shr[VW-1:0];
    if (mean == '0) begin
      mean = VW'(1);
    end
    gate_prod = GATE_PW'(last_ivl_r) * GATE_PW'(GATE_RECIP);
    gate_shr  = gate_prod >> GATE_SHIFT;
    gate_q    = gate_shr[ELAPSED_W-1:0];
    gate_calc = {gate_q, 1'b0} + {1'b0, gate_q};

    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    last_ivl_nxt  = last_ivl_r;
    gate_nxt      = gate_r;
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    thr_nxt       = thr_r;
    in_pulse_nxt  = in_pulse_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    bpm_nxt       = bpm_r;
    event_nxt     = event_r;
    sum_nxt       = sum_r;
    hist_push     = 1'b0;
    div_start     = 1'b0;
    div_dividend  = DW'(BPM_NUMERATOR);
    div_divisor   = mean;
    out_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          elapsed_nxt = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
          event_nxt   = 1'b0;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        peak_nxt   = peak1;
        trough_nxt = trough1;
        state_nxt  = S_EMIT;
        if (beat) begin
          in_pulse_nxt = 1'b1;
          last_ivl_nxt = elapsed_r;
          elapsed_nxt  = '0;
          if (first_r) begin
            first_nxt  = 1'b0;
            second_nxt = 1'b1;
            state_nxt  = S_GATE;
          end else begin
            second_nxt = 1'b0;
            hist_push  = 1'b1;
            event_nxt  = 1'b1;
            if (second_r) begin
              sum_nxt = SUM_W'(HISTORY_DEPTH) * SUM_W'(elapsed_r);
            end else begin
              sum_nxt = sum_r - SUM_W'(hist_r[0]) + SUM_W'(elapsed_r);
            end
            state_nxt = S_BPM_GO;
          end
        end else if (sample_r < thr_r && in_pulse_r) begin
          in_pulse_nxt = 1'b0;
          thr_nxt      = thr_sum[SAMPLE_W] ? SAMPLE_MAX : thr_sum[SAMPLE_W-1:0];
          peak_nxt     = thr_nxt;
          trough_nxt   = thr_nxt;
        end
        if (!(beat && first_r) && elapsed_r > {1'b0, timeout_r}) begin
          thr_nxt     = rest_r;
          peak_nxt    = rest_r;
          trough_nxt  = rest_r;
          elapsed_nxt = '0;
          first_nxt   = 1'b1;
          second_nxt  = 1'b0;
        end
      end
      S_BPM_GO: begin
        div_start = 1'b1;
        state_nxt = S_BPM_WAIT;
      end
      S_BPM_WAIT: begin
        if (div_done) begin
          bpm_nxt   = div_quo[BPM_W-1:0];
          state_nxt = S_GATE;
        end
      end
      S_GATE: begin
        gate_nxt  = gate_calc[ELAPSED_W-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
      last_ivl_r  <= ELAPSED_W'(LAST_IVL_RESET);
      gate_r      <= ELAPSED_W'(GATE_RESET);
      peak_r      <= REST_RESET;
      trough_r    <= REST_RESET;
      thr_r       <= THRESH_RESET;
      in_pulse_r  <= 1'b0;
      first_r     <= 1'b1;
      second_r    <= 1'b0;
      bpm_r       <= '0;
      event_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      elapsed_r   <= elapsed_nxt;
      last_ivl_r  <= last_ivl_nxt;
      gate_r      <= gate_nxt;
      peak_r      <= peak_nxt;
      trough_r    <= trough_nxt;
      thr_r       <= thr_nxt;
      in_pulse_r  <= in_pulse_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      bpm_r       <= bpm_nxt;
      event_r     <= event_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
    sum_r <= sum_nxt;
    if (hist_push) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_r[i] <= second_r ? elapsed_r : hist_r[i+1];
      end
      hist_r[HISTORY_DEPTH-1] <= elapsed_r;
    end
    if (out_load) begin
      o_pulse_r <= in_pulse_r;
      o_event_r <= event_r;
      o_bpm_r   <= bpm_r;
      o_ivl_r   <= (last_ivl_r > ELAPSED_W'(IVL_OUT_MAX)) ? IVL_OUT_MAX
                                                         : last_ivl_r[IVL_OUT_W-1:0];
      o_thr_r   <= thr_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_active    = o_pulse_r;
  assign out_beat_event      = o_event_r;
  assign out_bpm             = o_bpm_r;
  assign out_interval_ms     = o_ivl_r;
  assign out_threshold_level = o_thr_r;

  a_accept_to_eval : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EVAL) else $error("accepted sample not evaluated");
  a_event_in_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_event_r |-> o_pulse_r) else $error("beat event outside a pulse");
  a_done_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_BPM_WAIT)
    else $error("divider result with no waiting step");
  a_idle_div_free : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_busy) else $error("divider busy while idle");

endmodule

// File: hdl/pbd_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pbd_div
  import pbd_pkg::*;
#(
  parameter int DW = 20,
  parameter int VW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [VW:0]      trial;
  logic [VW:0]      diff;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(DW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = run_r;
  assign done     = done_r;
  assign quotient = quo_r;

  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r) else $error("divider started while busy");
  a_done_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r) && !run_r) else $error("done without a finished run");
  a_count_live : assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> cnt_r != '0) else $error("divider running with empty count");

endmodule
